// ===== hdl/lrupf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupf_pkg: shared types and constants
// Field widths, result codes and register indexes of the LRU frame core.
// ----------------------------------------------------------------------------
package lrupf_pkg;

   localparam int PAGE_W     = 16;
   localparam int FRAME_W    = 4;
   localparam int TIME_OUT_W = 32;
   localparam int FIU_W      = 5;
   localparam int LIMIT_W    = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_LIMIT    = 2'd1;

   localparam logic [FIU_W-1:0]   FIU_RESET   = 5'd16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FREE  = 2'd1,
      OUT_EVICT = 2'd2,
      OUT_RANGE = 2'd3
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_LAST   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// ===== hdl/lrupf_channels.sv =====
// ----------------------------------------------------------------------------
// lrupf channels: request and response interfaces
// Valid/ready channels carrying one page access and one lookup result.
// ----------------------------------------------------------------------------
interface lrupf_req_if;
   logic                        valid;
   logic                        ready;
   logic [lrupf_pkg::PAGE_W-1:0] vpage;

   modport source (output valid, output vpage, input ready);
   modport sink   (input valid, input vpage, output ready);
endinterface

interface lrupf_rsp_if;
   logic                             valid;
   logic                             ready;
   lrupf_pkg::outcome_type           outcome;
   logic [lrupf_pkg::FRAME_W-1:0]    frame;
   logic [lrupf_pkg::PAGE_W-1:0]     evicted_page;
   logic [lrupf_pkg::TIME_OUT_W-1:0] seq_num;

   modport source (output valid, output outcome, output frame, output evicted_page,
                   output seq_num, input ready);
   modport sink   (input valid, input outcome, input frame, input evicted_page,
                   input seq_num, output ready);
endinterface

// ===== hdl/lrupf_ram.sv =====
// ----------------------------------------------------------------------------
// lrupf_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears the cycle after its address.
// ----------------------------------------------------------------------------
module lrupf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lrupf_scan.sv =====
// ----------------------------------------------------------------------------
// lrupf_scan: frame table search
// Consumes one frame entry per cycle while rd_vld is high and tracks hit, first free and oldest.
// ----------------------------------------------------------------------------
module lrupf_scan #(
   parameter int FIDX_W    = 4,
   parameter int TIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          rd_vld,
   input  logic [FIDX_W-1:0]             rd_idx,
   input  logic                          rd_valid_bit,
   input  logic [lrupf_pkg::PAGE_W-1:0]  rd_page,
   input  logic [TIME_BITS-1:0]          rd_time,
   input  logic [lrupf_pkg::PAGE_W-1:0]  req_page,
   output lrupf_pkg::outcome_type        outcome,
   output logic [FIDX_W-1:0]             frame,
   output logic [lrupf_pkg::PAGE_W-1:0]  evicted_page
);
   import lrupf_pkg::*;

   logic                 hit_found_ff, hit_found_in;
   logic                 free_found_ff, free_found_in;
   logic [FIDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [FIDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [FIDX_W-1:0]    old_idx_ff, old_idx_in;
   logic [TIME_BITS-1:0] old_time_ff, old_time_in;
   logic [PAGE_W-1:0]    old_page_ff, old_page_in;

   always_comb begin
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      old_idx_in    = old_idx_ff;
      old_time_in   = old_time_ff;
      old_page_in   = old_page_ff;
      if (start) begin
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else if (rd_vld) begin
         if (rd_valid_bit) begin
            if (!hit_found_ff && (rd_page == req_page)) begin
               hit_found_in = 1'b1;
               hit_idx_in   = rd_idx;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx;
         end
         // entry 0 seeds the oldest search; strict compare keeps lowest index on ties
         if ((rd_idx == '0) || (rd_valid_bit && (rd_time < old_time_ff))) begin
            old_idx_in  = rd_idx;
            old_time_in = rd_time;
            old_page_in = rd_page;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      old_idx_ff  <= old_idx_in;
      old_time_ff <= old_time_in;
      old_page_ff <= old_page_in;
   end

   always_comb begin
      evicted_page = '0;
      if (hit_found_ff) begin
         outcome = OUT_HIT;
         frame   = hit_idx_ff;
      end else if (free_found_ff) begin
         outcome = OUT_FREE;
         frame   = free_idx_ff;
      end else begin
         outcome      = OUT_EVICT;
         frame        = old_idx_ff;
         evicted_page = old_page_ff;
      end
   end

endmodule

// ===== hdl/lru_page_frame_replacement_core.sv =====
// ----------------------------------------------------------------------------
// lru_page_frame_replacement_core: LRU frame allocator, inverted page table
// Looks up each page access, fills a free frame or evicts the oldest one.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one virtual page per transfer; rsp_ch returns one result
//   per access: outcome, frame, evicted page and the access sequence number.
//   csr_* writes frames_in_use (index 0) and page_limit (index 1); write only
//   while no access is in flight.
// Timing:
//   An in-range access scans the first n frame table entries, where n is
//   the active frame count (1..MAX_FRAMES): the frame table RAM is read one
//   entry per cycle, then the chosen entry is written back. An out-of-range
//   page skips the scan and goes straight to the result. One access is handled
//   at a time; req_ch is ready again the cycle after the result is registered.
// Reset:
//   Synchronous. All frames become free, the access counter returns to zero
//   and the registers take their defaults (16 frames, 65536 pages).
// Backpressure:
//   The result sits in an output register; while rsp_ch is stalled a finished
//   lookup waits before write-back, and no new access is taken while it waits.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement_core #(
   parameter int MAX_FRAMES = 16,
   parameter int TIME_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   lrupf_req_if.sink                         req_ch,
   lrupf_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  logic [lrupf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrupf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lrupf_pkg::*;

   localparam int FIDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CMP_W   = 9;
   localparam int FEXT_W  = (FIDX_W > FRAME_W) ? FIDX_W : FRAME_W;
   localparam int TEXT_W  = (TIME_BITS > TIME_OUT_W) ? TIME_BITS : TIME_OUT_W;
   localparam int ENTRY_W = PAGE_W + TIME_BITS;

   state_type state_ff, state_in;

   logic [FIU_W-1:0]      fiu_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [TIME_BITS-1:0]  counter_ff, counter_in;
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic                  range_ff, range_in;
   logic [FIDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                  rd_pend_ff;
   logic [FIDX_W-1:0]     rd_idx_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   outcome_type           rsp_outcome_ff;
   logic [FRAME_W-1:0]    rsp_frame_ff;
   logic [PAGE_W-1:0]     rsp_evicted_ff;
   logic [TIME_OUT_W-1:0] rsp_time_ff;

   logic                  req_xfer;
   logic                  finish_go;
   logic [CMP_W-1:0]      fiu_ext;
   logic [CMP_W-1:0]      last_ext;
   logic [FIDX_W-1:0]     last_idx;
   logic                  out_of_range;
   logic [ENTRY_W-1:0]    rd_entry;
   logic [ENTRY_W-1:0]    wr_entry;

   outcome_type           sc_outcome;
   logic [FIDX_W-1:0]     sc_frame;
   logic [PAGE_W-1:0]     sc_evicted;
   logic [FEXT_W-1:0]     frame_ext;
   logic [TEXT_W-1:0]     time_ext;

   // active frame count clamped to 1..MAX_FRAMES, kept as last index
   always_comb begin
      fiu_ext = CMP_W'(fiu_ff);
      if (fiu_ext == '0) begin
         last_ext = '0;
      end else if (fiu_ext > CMP_W'(MAX_FRAMES)) begin
         last_ext = CMP_W'(MAX_FRAMES - 1);
      end else begin
         last_ext = fiu_ext - CMP_W'(1);
      end
   end
   assign last_idx = last_ext[FIDX_W-1:0];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_of_range = ({1'b0, req_ch.vpage} >= limit_ff);
   assign finish_go    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in    = state_ff;
      page_in     = page_ff;
      range_in    = range_ff;
      scan_idx_in = scan_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               page_in     = req_ch.vpage;
               range_in    = out_of_range;
               scan_idx_in = '0;
               state_in    = out_of_range ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == last_idx) begin
               state_in = ST_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + FIDX_W'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_entry = {page_ff, counter_ff};

   lrupf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (finish_go && !range_ff),
      .wr_addr (sc_frame),
      .wr_data (wr_entry),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_entry)
   );

   lrupf_scan #(
      .FIDX_W    (FIDX_W),
      .TIME_BITS (TIME_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (req_xfer),
      .rd_vld       (rd_pend_ff),
      .rd_idx       (rd_idx_ff),
      .rd_valid_bit (valid_ff[rd_idx_ff]),
      .rd_page      (rd_entry[ENTRY_W-1:TIME_BITS]),
      .rd_time      (rd_entry[TIME_BITS-1:0]),
      .req_page     (page_ff),
      .outcome      (sc_outcome),
      .frame        (sc_frame),
      .evicted_page (sc_evicted)
   );

   always_comb begin
      valid_in   = valid_ff;
      counter_in = counter_ff;
      if (finish_go && !range_ff) begin
         valid_in[sc_frame] = 1'b1;
         counter_in         = counter_ff + TIME_BITS'(1);
      end
   end

   assign frame_ext = FEXT_W'(sc_frame);
   assign time_ext  = TEXT_W'(counter_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fiu_ff       <= FIU_RESET;
         limit_ff     <= LIMIT_RESET;
         counter_ff   <= '0;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         valid_ff     <= valid_in;
         rd_pend_ff   <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_FRAMES_IN_USE)) begin
            fiu_ff <= csr_wdata[FIU_W-1:0];
         end
         if (csr_we && (csr_index == CSR_PAGE_LIMIT)) begin
            limit_ff <= csr_wdata[LIMIT_W-1:0];
         end
      end
      page_ff     <= page_in;
      range_ff    <= range_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= scan_idx_ff;
      if (finish_go) begin
         rsp_time_ff <= time_ext[TIME_OUT_W-1:0];
         if (range_ff) begin
            rsp_outcome_ff <= OUT_RANGE;
            rsp_frame_ff   <= '0;
            rsp_evicted_ff <= '0;
         end else begin
            rsp_outcome_ff <= sc_outcome;
            rsp_frame_ff   <= frame_ext[FRAME_W-1:0];
            rsp_evicted_ff <= sc_evicted;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.outcome      = rsp_outcome_ff;
   assign rsp_ch.frame        = rsp_frame_ff;
   assign rsp_ch.evicted_page = rsp_evicted_ff;
   assign rsp_ch.seq_num      = rsp_time_ff;

endmodule

// ===== hdl/lrupf_checker.sv =====
// ----------------------------------------------------------------------------
// lrupf_checker: port-level assertions for the LRU frame core
// Watches the request and response channels; attached by bind.
// ----------------------------------------------------------------------------
module lrupf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input lrupf_pkg::outcome_type            rsp_outcome,
   input logic [lrupf_pkg::FRAME_W-1:0]     rsp_frame,
   input logic [lrupf_pkg::PAGE_W-1:0]      rsp_evicted_page,
   input logic [lrupf_pkg::TIME_OUT_W-1:0]  rsp_seq_num
);
   import lrupf_pkg::*;

   // a stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) && $stable(rsp_frame)
         && $stable(rsp_evicted_page) && $stable(rsp_seq_num))
      else $error("response changed while stalled");

   // one access in flight: no new transfer right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_range_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_RANGE) |-> (rsp_frame == '0) && (rsp_evicted_page == '0))
      else $error("out-of-range result carries a frame or page");

   a_evict_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome != OUT_EVICT) |-> (rsp_evicted_page == '0))
      else $error("evicted page without an eviction");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lru_page_frame_replacement_core lrupf_checker u_lrupf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_outcome      (rsp_ch.outcome),
   .rsp_frame        (rsp_ch.frame),
   .rsp_evicted_page (rsp_ch.evicted_page),
   .rsp_seq_num      (rsp_ch.seq_num)
);
